// ===== rtl/retro_bus_io_register_map_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the retro bus register map
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RETRO_BUS_IO_REGISTER_MAP_MACROS_SVH
`define RETRO_BUS_IO_REGISTER_MAP_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent holds -> consequent holds in the same cycle
`define RBIO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define RBIO_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RBIO_ASSERT_IMP(lbl, ante, cons, msg)
`define RBIO_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/rbio_pkg.sv =====
// ---------------------------------------------------------------------------
// rbio_pkg
// Shared types, action codes and register addresses of the bus register map.
// ---------------------------------------------------------------------------
package rbio_pkg;

    // access codes
    localparam logic [1:0] ACT_READ_BYTE = 2'd0;
    localparam logic [1:0] ACT_READ_WORD = 2'd1;
    localparam logic [1:0] ACT_WRITE     = 2'd2;

    // memory-mapped registers (octal bus addresses)
    localparam logic [15:0] ADDR_KBD_STAT   = 16'o177660;
    localparam logic [15:0] ADDR_KBD_STAT_H = 16'o177661;
    localparam logic [15:0] ADDR_KBD_DATA   = 16'o177662;
    localparam logic [15:0] ADDR_SCROLL_LO  = 16'o177664;
    localparam logic [15:0] ADDR_SCROLL_HI  = 16'o177665;
    localparam logic [15:0] ADDR_TMR_RELOAD = 16'o177706;
    localparam logic [15:0] ADDR_TMR_COUNT  = 16'o177710;
    localparam logic [15:0] ADDR_TMR_CTL_LO = 16'o177712;
    localparam logic [15:0] ADDR_TMR_CTL_HI = 16'o177713;
    localparam logic [15:0] ADDR_PAR_LO     = 16'o177714;
    localparam logic [15:0] ADDR_PAR_HI     = 16'o177715;
    localparam logic [15:0] ADDR_SYS_LO     = 16'o177716;
    localparam logic [15:0] ADDR_SYS_HI     = 16'o177717;

    // read-only windows
    localparam logic [15:0] ROM0_LO = 16'o100000;
    localparam logic [15:0] ROM0_HI = 16'o176560;
    localparam logic [15:0] ROM1_LO = 16'o176570;
    localparam logic [15:0] ROM1_HI = 16'o177660;
    localparam logic [15:0] ROM2_LO = 16'o177665;
    localparam logic [15:0] ROM2_HI = 16'o177706;
    localparam logic [15:0] ROM3_LO = 16'o177717;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;     // latch the input word
        logic clear_step;  // zero one memory row
        logic fetch;       // read both memory ports
        logic exec;        // main access / first write
        logic exec2;       // second write of a timer control access
        logic finish;      // result strobe next cycle
    } rbio_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic clear_last;  // last row of the clearing pass
        logic two_writes;  // access needs a second write cycle
    } rbio_stat_t;

endpackage

// ===== rtl/retro_bus_io_register_map.sv =====
// ---------------------------------------------------------------------------
// retro_bus_io_register_map
// Memory bus of a 16-bit home computer: 64 KiB byte store with register side
// effects, byte reads, word reads and byte writes.
// ---------------------------------------------------------------------------
// After reset the block zeroes its byte store one 16-bit row per cycle, which
// keeps busy high until every row is clear. An access is taken when start is
// high and busy is low. The store is read in a fetch state and any write is
// made in an exec state; a timer control register write takes a second exec
// state, as it updates two memory rows through the single write port. The
// result has a one-cycle done strobe, registered from the last exec state.
// Results cannot be stalled: sample read_data and access_error in the done
// cycle. A new access may be started in the same cycle that done is high.
// timer_running and system_out always show the current register values.
// ---------------------------------------------------------------------------
module retro_bus_io_register_map
    import rbio_pkg::*;
#(
    parameter int MEM_BYTES = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic [15:0] system_port_in,
    output logic        done,
    output logic [15:0] read_data,
    output logic        access_error,
    output logic        timer_running,
    output logic [15:0] system_out
);

    rbio_cmd_t  cmd;
    rbio_stat_t stat;

    // sequencer
    rbio_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // store and register datapath
    rbio_dpath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .action         (action),
        .address        (address),
        .write_data     (write_data),
        .system_port_in (system_port_in),
        .done           (done),
        .read_data      (read_data),
        .access_error   (access_error),
        .timer_running  (timer_running),
        .system_out     (system_out)
    );

endmodule

// ===== rtl/rbio_ctrl.sv =====
// ---------------------------------------------------------------------------
// rbio_ctrl
// Sequencer: clearing pass after reset, then fetch / execute per access.
// ---------------------------------------------------------------------------
module rbio_ctrl
    import rbio_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  rbio_stat_t stat,
    output rbio_cmd_t  cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_EXEC  = 3'd3;
    localparam logic [2:0] ST_EXEC2 = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.two_writes)
                begin
                    state_next = ST_EXEC2;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC2:
            begin
                cmd.exec2  = 1'b1;
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/rbio_dpath.sv =====
// ---------------------------------------------------------------------------
// rbio_dpath
// Byte store (two byte lanes), register side effects and result registers.
// ---------------------------------------------------------------------------
`include "retro_bus_io_register_map_macros.svh"

module rbio_dpath
    import rbio_pkg::*;
#(
    parameter int MEM_BYTES = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  rbio_cmd_t   cmd,
    output rbio_stat_t  stat,
    input  logic [1:0]  action,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic [15:0] system_port_in,
    output logic        done,
    output logic [15:0] read_data,
    output logic        access_error,
    output logic        timer_running,
    output logic [15:0] system_out
);

    localparam int ROWS  = MEM_BYTES / 2;
    localparam int ROW_W = $clog2(ROWS);

    localparam logic [ROW_W-1:0] ROW_STAT   = ADDR_KBD_STAT[ROW_W:1];
    localparam logic [ROW_W-1:0] ROW_RELOAD = ADDR_TMR_RELOAD[ROW_W:1];
    localparam logic [ROW_W-1:0] ROW_COUNT  = ADDR_TMR_COUNT[ROW_W:1];

    // read-only address windows
    function automatic logic is_rom(input logic [15:0] a);
        is_rom = (a >= ROM0_LO && a < ROM0_HI) ||
                 (a >= ROM1_LO && a < ROM1_HI) ||
                 (a >  ROM2_LO && a < ROM2_HI) ||
                 (a >  ROM3_LO);
    endfunction

    // two byte lanes: even addresses low, odd addresses high
    logic [7:0] mem_lo [ROWS];
    logic [7:0] mem_hi [ROWS];

    logic [1:0]       act_reg;
    logic [15:0]      addr_reg;
    logic [7:0]       wd_reg;
    logic [15:0]      port_reg;
    logic [ROW_W-1:0] clr_cnt_reg;
    logic [7:0]       rda_lo_reg;
    logic [7:0]       rda_hi_reg;
    logic [7:0]       rdb_lo_reg;
    logic [7:0]       rdb_hi_reg;
    logic [15:0]      rd_reg;
    logic [15:0]      rd_next;
    logic             err_reg;
    logic             err_next;
    logic             ten_reg;
    logic             ten_next;
    logic [15:0]      sys_reg;
    logic [15:0]      sys_next;
    logic             done_reg;

    logic             tmr_ctl;
    logic [ROW_W-1:0] row_a;
    logic [ROW_W-1:0] row_b;
    logic [15:0]      addr_al;
    logic [7:0]       bsel;
    logic [15:0]      wsel;
    logic             we_lo;
    logic             we_hi;
    logic [ROW_W-1:0] wrow;
    logic [7:0]       wlo;
    logic [7:0]       whi;

    // access word latch
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= action;
            addr_reg <= address;
            wd_reg   <= write_data;
            port_reg <= system_port_in;
        end
    end

    // clearing pass row counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign tmr_ctl = (act_reg == ACT_WRITE) &&
                     (addr_reg == ADDR_TMR_CTL_LO || addr_reg == ADDR_TMR_CTL_HI);

    assign stat.clear_last = (clr_cnt_reg == '1);
    assign stat.two_writes = tmr_ctl;

    // port A: accessed row; port B: keyboard status or timer reload row
    assign row_a = addr_reg[ROW_W:1];
    assign row_b = tmr_ctl ? ROW_RELOAD : ROW_STAT;

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            rda_lo_reg <= mem_lo[row_a];
            rda_hi_reg <= mem_hi[row_a];
            rdb_lo_reg <= mem_lo[row_b];
            rdb_hi_reg <= mem_hi[row_b];
        end
    end

    // memory write port
    always_ff @(posedge clk)
    begin
        if (we_lo)
        begin
            mem_lo[wrow] <= wlo;
        end
        if (we_hi)
        begin
            mem_hi[wrow] <= whi;
        end
    end

    assign addr_al = {addr_reg[15:1], 1'b0};
    assign bsel    = addr_reg[0] ? rda_hi_reg : rda_lo_reg;
    assign wsel    = {rda_hi_reg, rda_lo_reg};

    // access execution: result, side effects and write port control
    always_comb
    begin
        we_lo    = 1'b0;
        we_hi    = 1'b0;
        wrow     = row_a;
        wlo      = wd_reg;
        whi      = wd_reg;
        rd_next  = rd_reg;
        err_next = err_reg;
        ten_next = ten_reg;
        sys_next = sys_reg;
        if (cmd.clear_step)
        begin
            we_lo = 1'b1;
            we_hi = 1'b1;
            wrow  = clr_cnt_reg;
            wlo   = '0;
            whi   = '0;
        end
        else if (cmd.exec)
        begin
            rd_next  = '0;
            err_next = 1'b0;
            case (act_reg)
                ACT_READ_BYTE:
                begin
                    case (addr_reg)
                        ADDR_KBD_STAT:  rd_next = {8'h00, bsel & 8'o300};
                        ADDR_KBD_DATA:
                        begin
                            rd_next = {8'h00, bsel & 8'o177};
                            we_lo   = 1'b1;
                            wrow    = ROW_STAT;
                            wlo     = {1'b0, rdb_lo_reg[6:0]};
                        end
                        ADDR_SCROLL_HI: rd_next = {8'h00, bsel & 8'o002};
                        ADDR_SYS_LO:    rd_next = {8'h00, port_reg[7:0]};
                        ADDR_SYS_HI,
                        ADDR_PAR_LO,
                        ADDR_PAR_HI:    rd_next = '0;
                        default:        rd_next = {8'h00, bsel};
                    endcase
                end
                ACT_READ_WORD:
                begin
                    case (addr_al)
                        ADDR_KBD_STAT:   rd_next = wsel & 16'o000300;
                        ADDR_KBD_DATA:
                        begin
                            rd_next = wsel & 16'o000177;
                            we_lo   = 1'b1;
                            wrow    = ROW_STAT;
                            wlo     = {1'b0, rdb_lo_reg[6:0]};
                        end
                        ADDR_SCROLL_LO:  rd_next = wsel & 16'o001377;
                        ADDR_TMR_CTL_LO: rd_next = wsel | 16'hFF00;
                        ADDR_SYS_LO:     rd_next = port_reg;
                        ADDR_PAR_LO:     rd_next = '0;
                        default:         rd_next = wsel;
                    endcase
                end
                ACT_WRITE:
                begin
                    if (is_rom(addr_reg))
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        case (addr_reg)
                            ADDR_KBD_STAT:
                            begin
                                we_lo = 1'b1;
                                wlo   = {rda_lo_reg[7], wd_reg[6], 6'b000000};
                            end
                            ADDR_KBD_STAT_H:
                            begin
                                we_hi = 1'b1;
                                whi   = '0;
                            end
                            ADDR_SYS_LO:
                            begin
                                sys_next = (sys_reg & 16'hFF0F) | {8'h00, wd_reg & 8'hF0};
                            end
                            ADDR_SYS_HI:
                            begin
                                sys_next = sys_reg & 16'h00F0;
                            end
                            ADDR_SCROLL_HI:
                            begin
                                we_hi = 1'b1;
                                whi   = wd_reg & 8'o002;
                            end
                            ADDR_TMR_CTL_LO,
                            ADDR_TMR_CTL_HI:
                            begin
                                // reload word into counter; control byte next cycle
                                we_lo    = 1'b1;
                                we_hi    = 1'b1;
                                wrow     = ROW_COUNT;
                                wlo      = rdb_lo_reg;
                                whi      = rdb_hi_reg;
                                ten_next = addr_reg[0] ? 1'b1 : wd_reg[4];
                            end
                            default:
                            begin
                                we_lo = ~addr_reg[0];
                                we_hi = addr_reg[0];
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.exec2)
        begin
            // timer control byte; high byte always stored as all ones
            we_lo = ~addr_reg[0];
            we_hi = addr_reg[0];
            wlo   = wd_reg;
            whi   = 8'hFF;
        end
    end

    // result and port registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ten_reg  <= 1'b0;
            sys_reg  <= '0;
            done_reg <= 1'b0;
            err_reg  <= 1'b0;
        end
        else
        begin
            ten_reg  <= ten_next;
            sys_reg  <= sys_next;
            done_reg <= cmd.finish;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= rd_next;
    end

    assign done          = done_reg;
    assign read_data     = rd_reg;
    assign access_error  = err_reg;
    assign timer_running = ten_reg;
    assign system_out    = sys_reg;

    // checks
    `RBIO_ASSERT_IMP(a_err_on_write, done_reg && err_reg, act_reg == ACT_WRITE, "error flag on a non-write access")
    `RBIO_ASSERT_IMP(a_write_rd_zero, done_reg && act_reg == ACT_WRITE, rd_reg == 16'h0000, "write returned read data")
    `RBIO_ASSERT_IMP(a_timer_src, !$stable(ten_reg), $past(cmd.exec && tmr_ctl), "timer flag changed outside a control write")
    `RBIO_ASSERT_NXT(a_clear_quiet, cmd.clear_step, !done_reg, "result strobe during clearing pass")

endmodule

// ===== verif/tb_retro_bus_io_register_map.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_retro_bus_io_register_map
// Self-checking bench for the bus register map. A clocked driver issues bus
// accesses from a queue in random bursts. A shadow copy of the byte store,
// the timer flag and the system output port predicts each result, and a
// monitor checks every done strobe against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_retro_bus_io_register_map;
    import rbio_pkg::*;

    localparam int         CLK_PERIOD     = 8;
    localparam int         RESET_CYCLES   = 11;
    localparam int         RANDOM_WORDS   = 1400;
    localparam int         DRAIN_EVERY    = 350;
    // the clearing pass after reset has no accepts or results; keep the limit well above it
    localparam int         WATCHDOG_LIMIT = 150000;
    localparam int         PRINT_CAP      = 40;
    localparam logic [1:0] ACT_UNUSED     = 2'd3;

    typedef struct {
        logic [1:0]  act;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [15:0] port;
        bit          drain;   // hold off until every result is back
    } bus_word_t;

    typedef struct {
        logic [15:0] rdata;
        logic        err;
        logic        run;
        logic [15:0] sysout;
    } bus_result_t;

    // clock and ports
    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        start          = 1'b0;
    logic [1:0]  action         = ACT_READ_BYTE;
    logic [15:0] address        = '0;
    logic [7:0]  write_data     = '0;
    logic [15:0] system_port_in = '0;
    logic        busy;
    logic        done;
    logic [15:0] read_data;
    logic        access_error;
    logic        timer_running;
    logic [15:0] system_out;

    // shadow state
    bit [7:0]    shadow_mem [65536];
    bit          timer_on;
    bit [15:0]   sys_port_q;

    bus_word_t   pending_q[$];
    bus_result_t expected_q[$];

    int          burst_left;
    int          gap_left;
    int          idle_cycles;
    int          mismatches;
    int          results_seen;
    int          rom_refusals;
    int          kind_count [4];

    retro_bus_io_register_map dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .address        (address),
        .write_data     (write_data),
        .system_port_in (system_port_in),
        .done           (done),
        .read_data      (read_data),
        .access_error   (access_error),
        .timer_running  (timer_running),
        .system_out     (system_out)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // one access against the shadow state; returns what the bus should show
    function automatic bus_result_t run_access(input logic [1:0] act, input logic [15:0] addr,
                                               input logic [7:0] wd, input logic [15:0] port);
        bus_result_t r;
        logic [15:0] wa;
        logic [15:0] w;
        logic [7:0]  v;
        logic [7:0]  d;
        r.rdata = '0;
        r.err   = 1'b0;
        v  = shadow_mem[addr];
        d  = wd;
        wa = {addr[15:1], 1'b0};
        w  = {shadow_mem[wa + 16'd1], shadow_mem[wa]};
        case (act)
            ACT_READ_BYTE:
            begin
                case (addr)
                    ADDR_KBD_STAT:  r.rdata = {8'h00, v & 8'o300};
                    ADDR_KBD_DATA:
                    begin
                        // data read drops the ready bit
                        shadow_mem[ADDR_KBD_STAT][7] = 1'b0;
                        r.rdata = {8'h00, v & 8'o177};
                    end
                    ADDR_SCROLL_HI: r.rdata = {8'h00, v & 8'o002};
                    ADDR_SYS_LO:    r.rdata = {8'h00, port[7:0]};
                    ADDR_SYS_HI, ADDR_PAR_LO, ADDR_PAR_HI: r.rdata = '0;
                    default:        r.rdata = {8'h00, v};
                endcase
            end
            ACT_READ_WORD:
            begin
                case (wa)
                    ADDR_KBD_STAT:   r.rdata = w & 16'o300;
                    ADDR_KBD_DATA:
                    begin
                        shadow_mem[ADDR_KBD_STAT][7] = 1'b0;
                        r.rdata = w & 16'o177;
                    end
                    ADDR_SCROLL_LO:  r.rdata = w & 16'o1377;
                    ADDR_TMR_CTL_LO: r.rdata = w | 16'hFF00;
                    ADDR_SYS_LO:     r.rdata = port;
                    ADDR_PAR_LO:     r.rdata = '0;
                    default:         r.rdata = w;
                endcase
            end
            ACT_WRITE:
            begin
                if ((addr >= ROM0_LO && addr < ROM0_HI) ||
                    (addr >= ROM1_LO && addr < ROM1_HI) ||
                    (addr > ROM2_LO && addr < ROM2_HI) || (addr > ROM3_LO))
                begin
                    r.err = 1'b1;
                end
                else
                begin
                    case (addr)
                        ADDR_KBD_STAT:
                            shadow_mem[addr] = (shadow_mem[addr] & 8'o200) | (d & 8'o100);
                        ADDR_KBD_STAT_H: shadow_mem[addr] = 8'h00;
                        ADDR_SYS_LO:
                            sys_port_q = (sys_port_q & 16'hFF0F) | {8'h00, d & 8'hF0};
                        ADDR_SYS_HI:     sys_port_q = sys_port_q & 16'h00F0;
                        ADDR_SCROLL_HI:  shadow_mem[addr] = d & 8'o002;
                        ADDR_TMR_CTL_LO, ADDR_TMR_CTL_HI:
                        begin
                            // high byte write forces 0xFF, which starts the timer
                            if (addr == ADDR_TMR_CTL_HI)
                                d = 8'hFF;
                            shadow_mem[ADDR_TMR_COUNT] = shadow_mem[ADDR_TMR_RELOAD];
                            shadow_mem[ADDR_TMR_COUNT + 16'd1] =
                                shadow_mem[ADDR_TMR_RELOAD + 16'd1];
                            timer_on         = d[4];
                            shadow_mem[addr] = d;
                        end
                        default:         shadow_mem[addr] = d;
                    endcase
                end
            end
            default: ;  // unused code leaves everything alone
        endcase
        r.run    = timer_on;
        r.sysout = sys_port_q;
        return r;
    endfunction

    task automatic add_word(input logic [1:0] act, input logic [15:0] addr,
                            input logic [7:0] wd, input logic [15:0] port, input bit drain);
        bus_word_t w;
        w.act   = act;
        w.addr  = addr;
        w.wdata = wd;
        w.port  = port;
        w.drain = drain;
        pending_q.push_back(w);
    endtask

    task automatic note_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("%0t ns  MISMATCH  %s", $time, msg);
        mismatches++;
    endtask

    // random address biased toward the register window and a small RAM patch
    function automatic logic [15:0] pick_address();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            return 16'o177600 + 16'($urandom_range(0, 8'o177));
        else if (sel < 60)
            return 16'($urandom_range(0, 63));
        else if (sel < 70)
            return 16'o176550 + 16'($urandom_range(0, 31));
        else if (sel < 80)
            return 16'($urandom_range(16'o100000, 16'o177657));
        else
            return 16'($urandom());
    endfunction

    function automatic logic [1:0] pick_action();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return ACT_WRITE;
        else if (sel < 70)
            return ACT_READ_BYTE;
        else if (sel < 95)
            return ACT_READ_WORD;
        else
            return ACT_UNUSED;
    endfunction

    // driver: takes the next word when the current one is accepted
    always @(posedge clk)
    begin : feed_bus
        logic      took;
        logic      holding;
        bus_word_t w;
        took    = rst_n && start && !busy;
        holding = start && !took;
        if (took)
        begin
            expected_q.push_back(run_access(action, address, write_data, system_port_in));
            kind_count[action]++;
        end
        if (rst_n && !holding)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_q.size() != 0 && !(pending_q[0].drain && expected_q.size() != 0))
            begin
                w = pending_q.pop_front();
                start          <= 1'b1;
                action         <= w.act;
                address        <= w.addr;
                write_data     <= w.wdata;
                system_port_in <= w.port;
                if (burst_left <= 1)
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                             : $urandom_range(1, 12);
                    gap_left   = $urandom_range(1, 9);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every done strobe against the oldest prediction
    always @(posedge clk)
    begin : check_results
        bus_result_t want;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                note_mismatch("done strobe with no access outstanding");
            end
            else
            begin
                want = expected_q.pop_front();
                results_seen++;
                if (want.err)
                    rom_refusals++;
                if (read_data !== want.rdata)
                    note_mismatch($sformatf("read_data %h, want %h", read_data, want.rdata));
                if (access_error !== want.err)
                    note_mismatch($sformatf("access_error %b, want %b", access_error, want.err));
                if (timer_running !== want.run)
                    note_mismatch($sformatf("timer_running %b, want %b", timer_running, want.run));
                if (system_out !== want.sysout)
                    note_mismatch($sformatf("system_out %h, want %h", system_out, want.sysout));
            end
        end
    end

    // watchdog on cycles with neither an accept nor a result
    always @(posedge clk)
    begin : watchdog
        if (rst_n && ((start && !busy) || done))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("[retro_bus_io_register_map] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        burst_left = 1;
        gap_left   = 0;

        // directed: edges of the map and each register side effect
        add_word(ACT_UNUSED,    16'hFFFF,          8'hFF, 16'hFFFF, 1'b0);
        add_word(ACT_READ_BYTE, 16'h0000,          8'h00, 16'h0000, 1'b0);
        add_word(ACT_WRITE,     16'h0000,          8'hFF, 16'h0000, 1'b0);
        add_word(ACT_WRITE,     16'hFFFF,          8'hA5, 16'h0000, 1'b0);
        add_word(ACT_WRITE,     ROM0_LO,           8'h01, 16'h0000, 1'b0);
        add_word(ACT_WRITE,     16'o176557,        8'h11, 16'h0000, 1'b0);
        add_word(ACT_WRITE,     16'o176560,        8'h80, 16'h0000, 1'b0);
        add_word(ACT_READ_WORD, 16'o176561,        8'h00, 16'h0000, 1'b0);
        add_word(ACT_WRITE,     ADDR_KBD_STAT,     8'hFF, 16'h0000, 1'b0);
        add_word(ACT_WRITE,     ADDR_KBD_STAT_H,   8'hFF, 16'h0000, 1'b0);
        add_word(ACT_WRITE,     ADDR_KBD_DATA,     8'hFF, 16'h0000, 1'b0);
        add_word(ACT_READ_BYTE, ADDR_KBD_DATA,     8'h00, 16'h0000, 1'b0);
        add_word(ACT_READ_WORD, ADDR_KBD_STAT,     8'h00, 16'h0000, 1'b0);
        add_word(ACT_WRITE,     ADDR_SCROLL_LO,    8'hFF, 16'h0000, 1'b0);
        add_word(ACT_WRITE,     ADDR_SCROLL_HI,    8'hFF, 16'h0000, 1'b0);
        add_word(ACT_READ_WORD, ADDR_SCROLL_HI,    8'h00, 16'h0000, 1'b0);
        add_word(ACT_WRITE,     ADDR_TMR_RELOAD,   8'h5A, 16'h0000, 1'b0);
        add_word(ACT_WRITE,     ADDR_TMR_RELOAD + 16'd1, 8'hC3, 16'h0000, 1'b0);
        add_word(ACT_WRITE,     ADDR_TMR_CTL_LO,   8'h10, 16'h0000, 1'b0);
        add_word(ACT_READ_WORD, ADDR_TMR_COUNT,    8'h00, 16'h0000, 1'b0);
        add_word(ACT_WRITE,     ADDR_TMR_CTL_HI,   8'h00, 16'h0000, 1'b0);
        add_word(ACT_READ_WORD, ADDR_TMR_CTL_LO,   8'h00, 16'h0000, 1'b0);
        add_word(ACT_WRITE,     ADDR_SYS_LO,       8'hFF, 16'h0000, 1'b0);
        add_word(ACT_WRITE,     ADDR_SYS_HI,       8'h00, 16'h0000, 1'b0);
        add_word(ACT_READ_BYTE, ADDR_SYS_LO,       8'h00, 16'hFFFF, 1'b0);
        add_word(ACT_READ_WORD, ADDR_SYS_HI,       8'h00, 16'h8001, 1'b0);
        add_word(ACT_READ_WORD, ADDR_PAR_LO,       8'h00, 16'hFFFF, 1'b0);

        // random traffic, draining the pipe now and then
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            add_word(pick_action(), pick_address(),
                     ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom()),
                     16'($urandom()), (i % DRAIN_EVERY) == 0);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || start || expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("checked %0d results: %0d byte reads, %0d word reads, %0d writes, %0d unused",
                 results_seen, kind_count[ACT_READ_BYTE], kind_count[ACT_READ_WORD],
                 kind_count[ACT_WRITE], kind_count[ACT_UNUSED]);
        $display("read-only writes refused: %0d, mismatches: %0d", rom_refusals, mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("[retro_bus_io_register_map] OK");
        else
            $display("[retro_bus_io_register_map] ERROR");
        $finish;
    end

endmodule
